// File: hw/rtl/btnar_pkg.sv
// Shared types, reset values and register indexes for the button autorepeat block.
package btnar_pkg;

    localparam int unsigned MASK_W   = 32;
    localparam int unsigned TIME_W   = 32;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [TIME_W-1:0] INITIAL_DELAY_RST   = TIME_W'(500000);
    localparam logic [TIME_W-1:0] REPEAT_INTERVAL_RST = TIME_W'(100000);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INITIAL_DELAY   = 2'd0,
        CFG_REPEAT_INTERVAL = 2'd1
    } t_cfg_idx;

    typedef struct packed {
        logic [MASK_W-1:0] button_mask;
        logic [TIME_W-1:0] time_us;
        logic [MASK_W-1:0] query_mask;
    } t_in_word;

    typedef struct packed {
        logic [MASK_W-1:0] repeat_mask;
        logic              newly_pressed;
        logic [MASK_W-1:0] held_bits;
    } t_out_word;

    typedef struct packed {
        logic [TIME_W-1:0] initial_delay;
        logic [TIME_W-1:0] repeat_interval;
    } t_cfg;

endpackage

// File: hw/rtl/btnar_if.sv
// Handshake channels: poll words in, report words out, register writes.
interface btnar_in_if;
    logic                           valid;
    logic                           ready;
    logic [btnar_pkg::MASK_W-1:0]   button_mask;
    logic [btnar_pkg::TIME_W-1:0]   time_us;
    logic [btnar_pkg::MASK_W-1:0]   query_mask;

    modport source (output valid, output button_mask, output time_us, output query_mask,
                    input ready);
    modport sink   (input valid, input button_mask, input time_us, input query_mask,
                    output ready);
endinterface

interface btnar_out_if;
    logic                           valid;
    logic                           ready;
    logic [btnar_pkg::MASK_W-1:0]   repeat_mask;
    logic                           newly_pressed;
    logic [btnar_pkg::MASK_W-1:0]   held_bits;

    modport source (output valid, output repeat_mask, output newly_pressed,
                    output held_bits, input ready);
    modport sink   (input valid, input repeat_mask, input newly_pressed,
                    input held_bits, output ready);
endinterface

interface btnar_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [btnar_pkg::CFG_IDX_W-1:0]  index;
    logic [btnar_pkg::TIME_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/btnar_in_stage.sv
// Input register: captures one poll word and holds it until the core takes it.
module btnar_in_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    btnar_in_if.sink            i_in,
    input  logic                i_take,
    output logic                o_valid,
    output btnar_pkg::t_in_word o_word
);

    logic                r_valid;
    btnar_pkg::t_in_word r_word;

    // free when empty, or when the held word leaves this cycle
    assign i_in.ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_word.button_mask <= i_in.button_mask;
            r_word.time_us     <= i_in.time_us;
            r_word.query_mask  <= i_in.query_mask;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

// File: hw/rtl/btnar_core.sv
// Typematic core: held-mask state, elapsed-time compares and the report word.
module btnar_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_adv,
    input  btnar_pkg::t_in_word  i_word,
    input  btnar_pkg::t_cfg      i_cfg,
    output btnar_pkg::t_out_word o_word
);

    logic [btnar_pkg::MASK_W-1:0] r_cur_buttons;
    logic [btnar_pkg::TIME_W-1:0] r_change_time;
    logic [btnar_pkg::TIME_W-1:0] r_repeat_time;

    logic                         same;
    logic [btnar_pkg::TIME_W-1:0] since_change;
    logic [btnar_pkg::TIME_W-1:0] since_repeat;
    logic                         fire;
    logic                         all_now;
    logic                         all_before;

    always_comb begin
        same         = (i_word.button_mask == r_cur_buttons);
        // modulo 2^32 differences: a backwards stamp reads as a long wait
        since_change = i_word.time_us - r_change_time;
        since_repeat = i_word.time_us - r_repeat_time;
        fire         = (since_change >= i_cfg.initial_delay) &&
                       (since_repeat >= i_cfg.repeat_interval);
        all_now      = ((i_word.button_mask & i_word.query_mask) == i_word.query_mask);
        all_before   = ((r_cur_buttons & i_word.query_mask) == i_word.query_mask);

        o_word.repeat_mask   = (!same || fire) ? i_word.button_mask : '0;
        o_word.newly_pressed = all_now && !all_before;
        o_word.held_bits     = i_word.button_mask & i_word.query_mask;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_buttons <= '0;
            r_change_time <= '0;
            r_repeat_time <= '0;
        end else if (i_adv) begin
            if (!same) begin
                r_cur_buttons <= i_word.button_mask;
                r_change_time <= i_word.time_us;
                r_repeat_time <= i_word.time_us;
            end else if (fire) begin
                r_repeat_time <= i_word.time_us;
            end
        end
    end

endmodule

// File: hw/rtl/button_autorepeat_edge_detect.sv
// Top level of the button autorepeat and edge detect block.
// Each poll word (button mask, microsecond stamp, query mask) gives exactly one report
// word. A changed mask is reported at once; an unchanged mask reports zero until
// initial_delay microseconds have passed since the change, and then once per
// repeat_interval. Elapsed times are taken modulo 2^32. newly_pressed flags that every
// queried button is down now and was not all down on the previous poll; held_bits is
// the mask ANDed with the query. A word passes an input register and then the core's
// compare-and-subtract logic into an output register; one poll is accepted per cycle as
// long as the report side keeps taking words. The only loop is the state update in the
// core, through its state registers. Registers are written through the cfg channel,
// which is always ready; write them only while no poll is in flight.
module button_autorepeat_edge_detect (
    input  logic        i_clk,
    input  logic        i_rst_n,
    btnar_in_if.sink    i_in,
    btnar_out_if.source o_out,
    btnar_cfg_if.sink   i_cfg
);

    btnar_pkg::t_cfg      r_cfg;
    btnar_pkg::t_in_word  in_word;
    btnar_pkg::t_out_word core_word;
    btnar_pkg::t_out_word r_out_word;
    logic                 r_out_valid;
    logic                 in_valid;
    logic                 out_free;
    logic                 take;

    // register writes: always accepted, unknown indexes dropped
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.initial_delay   <= btnar_pkg::INITIAL_DELAY_RST;
            r_cfg.repeat_interval <= btnar_pkg::REPEAT_INTERVAL_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                btnar_pkg::CFG_INITIAL_DELAY:   r_cfg.initial_delay   <= i_cfg.data;
                btnar_pkg::CFG_REPEAT_INTERVAL: r_cfg.repeat_interval <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // advance the held word into the output register when that register is free
    assign out_free = !r_out_valid || o_out.ready;
    assign take     = in_valid && out_free;

    btnar_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (take),
        .o_valid (in_valid),
        .o_word  (in_word)
    );

    btnar_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (take),
        .i_word  (in_word),
        .i_cfg   (r_cfg),
        .o_word  (core_word)
    );

    // output register: hold the report until the sink takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out_word <= core_word;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.repeat_mask   = r_out_word.repeat_mask;
    assign o_out.newly_pressed = r_out_word.newly_pressed;
    assign o_out.held_bits     = r_out_word.held_bits;

endmodule

// File: hw/rtl/btnar_checker.sv
// Port-level checks for the button autorepeat block, bound to the top level.
module btnar_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [btnar_pkg::MASK_W-1:0]  i_repeat_mask,
    input logic                          i_newly_pressed,
    input logic [btnar_pkg::MASK_W-1:0]  i_held_bits
);

    // a fresh press is a mask change, so it is always reported with a nonempty mask
    a_press_reported: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_newly_pressed) |-> (i_repeat_mask != '0))
        else $error("newly pressed word without a report");

    // on a fresh press the held query buttons are part of the reported mask
    a_press_held_in_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_newly_pressed) |->
            ((i_held_bits != '0) && ((i_held_bits & ~i_repeat_mask) == '0)))
        else $error("held buttons missing from fresh press report");

    // input backs off only while a finished word waits on the output
    a_backpressure_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> (i_out_valid && !i_out_ready))
        else $error("input stalled with output free");

    // stalled report word stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_repeat_mask) && $stable(i_newly_pressed)
             && $stable(i_held_bits)))
        else $error("stalled output word changed");

endmodule

bind button_autorepeat_edge_detect btnar_checker u_btnar_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_repeat_mask   (o_out.repeat_mask),
    .i_newly_pressed (o_out.newly_pressed),
    .i_held_bits     (o_out.held_bits)
);
